[rtl/assert_macros.svh]
// Assertion macros shared by the route table RTL.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/dvrt_pkg.sv]
// Shared types and constants of the distance-vector route table.
// Depends on nothing; every other file but assert_macros.svh imports it.
package dvrt_pkg;

  // Table geometry and field widths.
  localparam int NodeCount   = 64;
  localparam int LinkCount   = 16;
  localparam int DistBits    = 16;
  localparam int DestBits    = $clog2(NodeCount);
  localparam int LinkBits    = $clog2(LinkCount);
  localparam int SelfIdBits  = 6;
  localparam int PDataBits   = 32;
  localparam int CfgAddrBits = 3;

  // All-ones distance stands for infinity.
  localparam logic [DistBits-1:0] DistInf = {DistBits{1'b1}};

  // Register index of the configuration port (byte address divided by four).
  localparam logic REG_SELF_ID = 1'b0;

  typedef enum logic [1:0] {
    OP_ESTABLISH  = 2'd0,
    OP_MERGE      = 2'd1,
    OP_LOOKUP     = 2'd2,
    OP_RESET_DIST = 2'd3
  } opcode_t;

  typedef logic [DestBits-1:0]   dest_t;
  typedef logic [LinkBits-1:0]   link_t;
  typedef logic [DistBits-1:0]   dist_t;
  typedef logic [SelfIdBits-1:0] self_id_t;

  // One request transaction.
  typedef struct packed {
    opcode_t opcode;
    dest_t   dest;
    link_t   link_id;
    dist_t   link_weight;
    dist_t   nbr_distance;
  } item_t;

  // Stored route of one destination.
  typedef struct packed {
    link_t link;
    dist_t distance;
  } route_t;

  // Write command toward the route memory.
  typedef struct packed {
    logic   en;
    dest_t  addr;
    route_t data;
  } route_wr_t;

  // One response transaction.
  typedef struct packed {
    logic  found;
    link_t route_link;
    dist_t route_distance;
    logic  updated;
  } result_t;

endpackage

[rtl/dvrt_channels.sv]
// Valid/ready channel interfaces for requests and responses of the route table.
// Depends on dvrt_pkg.
interface dvrt_req_if;
  import dvrt_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  dest_t   dest;
  link_t   link_id;
  dist_t   link_weight;
  dist_t   nbr_distance;

  modport source (output valid, opcode, dest, link_id, link_weight, nbr_distance,
                  input ready);
  modport sink (input valid, opcode, dest, link_id, link_weight, nbr_distance,
                output ready);
endinterface

interface dvrt_rsp_if;
  import dvrt_pkg::*;

  logic  valid;
  logic  ready;
  logic  found;
  link_t route_link;
  dist_t route_distance;
  logic  updated;

  modport source (output valid, found, route_link, route_distance, updated,
                  input ready);
  modport sink (input valid, found, route_link, route_distance, updated,
                output ready);
endinterface

[rtl/dvrt_apb_regs.sv]
// APB-style configuration register block holding this node's id.
// Depends on dvrt_pkg.
module dvrt_apb_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dvrt_pkg::CfgAddrBits-1:0]    paddr,
  input  logic [dvrt_pkg::PDataBits-1:0]      pwdata,
  output logic [dvrt_pkg::PDataBits-1:0]      prdata,
  output logic                                pready,
  output dvrt_pkg::self_id_t                  self_id
);
  import dvrt_pkg::*;

  logic reg_index;
  logic wr_fire;

  // The register index is the word address; the byte offset is ignored.
  assign reg_index = paddr[CfgAddrBits-1];
  assign wr_fire   = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Register write on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id <= '0;
    end else if (wr_fire && (reg_index == REG_SELF_ID)) begin
      self_id <= pwdata[SelfIdBits-1:0];
    end
  end

  // Read data mux; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_index == REG_SELF_ID) begin
      prdata = {{(PDataBits-SelfIdBits){1'b0}}, self_id};
    end
  end
endmodule

[rtl/dvrt_route_mem.sv]
// Route memory: one link and distance per destination, one write and one read port.
// Depends on dvrt_pkg. Read data is registered and bypasses a same-cycle write.
module dvrt_route_mem (
  input  logic                clk,
  input  logic                rd_en,
  input  dvrt_pkg::dest_t     rd_addr,
  output dvrt_pkg::route_t    rd_data,
  input  dvrt_pkg::route_wr_t wr
);
  import dvrt_pkg::*;

  route_t mem [NodeCount];

  // Write port, and registered read with write-through forwarding so that a
  // transaction read at the same edge as the previous one's write sees it.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end
endmodule

[rtl/dvrt_relax.sv]
// Update logic: decides the table write and the response for one request.
// Depends on dvrt_pkg. Purely combinational, sits between the request and result registers.
module dvrt_relax (
  input  logic                go,
  input  dvrt_pkg::item_t     item,
  input  logic                present,
  input  logic                stale,
  input  dvrt_pkg::route_t    stored,
  input  dvrt_pkg::self_id_t  self_id,
  output dvrt_pkg::route_wr_t wr,
  output dvrt_pkg::result_t   res
);
  import dvrt_pkg::*;

  logic [DistBits:0] sum_full;
  dist_t             sum;
  dist_t             cur_dist;
  logic              do_write;
  dist_t             new_dist;

  // Path cost through the neighbor, saturated at infinity.
  assign sum_full = {1'b0, item.link_weight} + {1'b0, item.nbr_distance};
  assign sum      = sum_full[DistBits] ? DistInf : sum_full[DistBits-1:0];

  // A stale entry compares as infinitely far.
  assign cur_dist = stale ? DistInf : stored.distance;

  // Decide whether the entry is rewritten and with which distance.
  always_comb begin
    do_write = 1'b0;
    new_dist = item.link_weight;
    unique case (item.opcode)
      OP_ESTABLISH: begin
        do_write = 1'b1;
        new_dist = item.link_weight;
      end
      OP_MERGE: begin
        do_write = (item.dest != self_id) && (!present || (cur_dist > sum));
        new_dist = sum;
      end
      OP_LOOKUP, OP_RESET_DIST: begin
        do_write = 1'b0;
      end
      default: begin
        do_write = 1'b0;
      end
    endcase
  end

  assign wr.en            = go && do_write;
  assign wr.addr          = item.dest;
  assign wr.data.link     = item.link_id;
  assign wr.data.distance = new_dist;

  // Response describes the entry as it stands after this request.
  always_comb begin
    res.updated = do_write;
    if (do_write) begin
      res.found          = 1'b1;
      res.route_link     = item.link_id;
      res.route_distance = new_dist;
    end else if (present) begin
      res.found          = 1'b1;
      res.route_link     = stored.link;
      res.route_distance = (stale || (item.opcode == OP_RESET_DIST)) ? DistInf : stored.distance;
    end else begin
      res.found          = 1'b0;
      res.route_link     = '0;
      res.route_distance = DistInf;
    end
  end
endmodule

[rtl/distance_vector_route_table.sv]
// Distance-vector route table: 64 destinations, each with a present flag, a stale
// flag, an outgoing link and a 16-bit distance (all ones is infinity). It takes one
// request transaction per clock cycle unless the response channel stalls, and returns
// one response per request, in order. A request is registered together with a read of
// the route memory at its destination; then the update logic relaxes the entry
// (establish, merge, lookup or reset distances), writes the memory and loads the
// response register, so throughput is one transaction per cycle while the response
// channel accepts; the route memory read path forwards the previous write. Present and
// stale flags live in flip-flops and reset clears them at once, so the block is ready
// right after reset with no clearing pass; a reset distances request marks every entry
// stale. The node id sits in an APB register at byte address 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Depends on dvrt_pkg, dvrt_channels, dvrt_apb_regs, dvrt_route_mem, dvrt_relax.
`include "assert_macros.svh"

module distance_vector_route_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dvrt_pkg::CfgAddrBits-1:0] paddr,
  input  logic [dvrt_pkg::PDataBits-1:0]   pwdata,
  output logic [dvrt_pkg::PDataBits-1:0]   prdata,
  output logic                             pready,
  dvrt_req_if.sink                         req,
  dvrt_rsp_if.source                       rsp
);
  import dvrt_pkg::*;

  self_id_t              self_id;
  logic                  s1_valid;
  item_t                 s1_item;
  logic                  s1_move;
  logic                  accept;
  route_t                rd_data;
  route_wr_t             wr;
  result_t               res;
  logic                  out_valid;
  result_t               out_res;
  logic [NodeCount-1:0]  present_q;
  logic [NodeCount-1:0]  stale_q;

  // Configuration registers.
  dvrt_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .self_id (self_id)
  );

  // Handshake: the request stage advances when the response register is free.
  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;

  // Route memory, read at the destination of the incoming transaction.
  dvrt_route_mem u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (req.dest),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // Relaxation and response logic for the registered request.
  dvrt_relax u_relax (
    .go      (s1_move),
    .item    (s1_item),
    .present (present_q[s1_item.dest]),
    .stale   (stale_q[s1_item.dest]),
    .stored  (rd_data),
    .self_id (self_id),
    .wr      (wr),
    .res     (res)
  );

  // Request stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Request stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.opcode       <= req.opcode;
      s1_item.dest         <= req.dest;
      s1_item.link_id      <= req.link_id;
      s1_item.link_weight  <= req.link_weight;
      s1_item.nbr_distance <= req.nbr_distance;
    end
  end

  // Present and stale flags of every destination.
  always_ff @(posedge clk) begin
    if (rst) begin
      present_q <= '0;
      stale_q   <= '0;
    end else if (s1_move) begin
      if (s1_item.opcode == OP_RESET_DIST) begin
        stale_q <= '1;
      end else if (wr.en) begin
        present_q[wr.addr] <= 1'b1;
        stale_q[wr.addr]   <= 1'b0;
      end
    end
  end

  // Response register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Response register payload.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.found          = out_res.found;
  assign rsp.route_link     = out_res.route_link;
  assign rsp.route_distance = out_res.route_distance;
  assign rsp.updated        = out_res.updated;

  // A reset distances transaction leaves every entry stale.
  `ASSERT_NXT(a_reset_all_stale, clk, rst, s1_move && (s1_item.opcode == OP_RESET_DIST), &stale_q)
  // A table write leaves its entry present and fresh.
  `ASSERT_NXT(a_write_fresh, clk, rst, wr.en, present_q[$past(wr.addr)] && !stale_q[$past(wr.addr)])
  // An updated response always reports a found entry.
  `ASSERT_IMP(a_updated_found, clk, rst, rsp.valid && rsp.updated, rsp.found)
  // A missing entry reports link zero at infinite distance.
  `ASSERT_IMP(a_miss_fields, clk, rst, rsp.valid && !rsp.found, (rsp.route_link == '0) && (rsp.route_distance == DistInf))
endmodule

[tb/tb_distance_vector_route_table.sv]
// Self-checking testbench for distance_vector_route_table: directed and random route
// transactions against an in-bench table predictor, with random idling on both channels.
// Depends on dvrt_pkg, dvrt_channels and the distance_vector_route_table RTL.
module tb_distance_vector_route_table;
  import dvrt_pkg::*;

  localparam int QuietLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [PDataBits-1:0] pwdata = '0;
  logic [PDataBits-1:0] prdata;
  logic pready;

  dvrt_req_if req_ch ();
  dvrt_rsp_if rsp_ch ();

  distance_vector_route_table dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always #2 clk = ~clk;

  // Predicted table contents and node id.
  logic     tbl_present [NodeCount];
  logic     tbl_stale [NodeCount];
  link_t    tbl_link [NodeCount];
  dist_t    tbl_dist [NodeCount];
  self_id_t node_id;

  item_t   route_requests [$];
  result_t expected_routes [$];
  item_t   cur_req;
  result_t want_route;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      failures = 0;
  int      quiet_cycles = 0;

  // Applies one request to the predicted table and returns the response it causes.
  function automatic result_t route_table_step(item_t it);
    result_t     r;
    logic [16:0] wide;
    dist_t       sum;
    dist_t       cur;
    int          i;
    r = '0;
    case (it.opcode)
      OP_RESET_DIST: begin
        for (i = 0; i < NodeCount; i++) tbl_stale[i] = 1'b1;
      end
      OP_ESTABLISH: begin
        tbl_present[it.dest] = 1'b1;
        tbl_stale[it.dest] = 1'b0;
        tbl_link[it.dest] = it.link_id;
        tbl_dist[it.dest] = it.link_weight;
        r.updated = 1'b1;
      end
      OP_MERGE: begin
        if (it.dest != node_id) begin
          wide = {1'b0, it.link_weight} + {1'b0, it.nbr_distance};
          if (it.link_weight == DistInf || it.nbr_distance == DistInf || wide > DistInf)
            sum = DistInf;
          else
            sum = wide[DistBits-1:0];
          cur = tbl_stale[it.dest] ? DistInf : tbl_dist[it.dest];
          if (!tbl_present[it.dest] || cur > sum) begin
            tbl_present[it.dest] = 1'b1;
            tbl_stale[it.dest] = 1'b0;
            tbl_link[it.dest] = it.link_id;
            tbl_dist[it.dest] = sum;
            r.updated = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (tbl_present[it.dest]) begin
      r.found = 1'b1;
      r.route_link = tbl_link[it.dest];
      r.route_distance = tbl_stale[it.dest] ? DistInf : tbl_dist[it.dest];
    end else begin
      r.found = 1'b0;
      r.route_link = '0;
      r.route_distance = DistInf;
    end
    return r;
  endfunction

  function automatic item_t make_item(opcode_t op, dest_t d, link_t l, dist_t w, dist_t nd);
    item_t it;
    it.opcode = op;
    it.dest = d;
    it.link_id = l;
    it.link_weight = w;
    it.nbr_distance = nd;
    return it;
  endfunction

  // Appends one request to the pending queue of the driver.
  function automatic void queue_request(item_t it);
    route_requests = {route_requests, it};
  endfunction

  // Distances lean toward small values and the saturation edge, with some full range.
  function automatic dist_t pick_distance(dist_t top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return dist_t'($urandom_range(0, 30));
    if (r < 53) return '0;
    if (r < 63) return top;
    if (r < 75) return dist_t'($urandom_range(60000, top));
    return dist_t'($urandom_range(0, top));
  endfunction

  // Random request; most destinations come from a small pool so that merges meet entries.
  function automatic item_t random_request();
    item_t   it;
    opcode_t op;
    dest_t   d;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 20) op = OP_ESTABLISH;
    else if (r < 72) op = OP_MERGE;
    else if (r < 97) op = OP_LOOKUP;
    else op = OP_RESET_DIST;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      r = $urandom_range(0, 11);
      d = (r < 6) ? dest_t'(r) : dest_t'(52 + r);
    end else if (r < 65) begin
      d = node_id;
    end else begin
      d = dest_t'($urandom_range(0, NodeCount - 1));
    end
    it = make_item(op, d, link_t'($urandom_range(0, LinkCount - 1)),
                   pick_distance(16'hFFFE), pick_distance(DistInf));
    return it;
  endfunction

  // Gap length after a transaction: none unless a pct-percent draw hits, then mostly short, a few long.
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request driver: the predictor runs on each accepted transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_routes = {expected_routes, route_table_step(cur_req)};
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (route_requests.size() > 0) begin
          cur_req = route_requests.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.opcode <= cur_req.opcode;
          req_ch.dest <= cur_req.dest;
          req_ch.link_id <= cur_req.link_id;
          req_ch.link_weight <= cur_req.link_weight;
          req_ch.nbr_distance <= cur_req.nbr_distance;
          gap_left = pick_gap(idle_pct);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_routes.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected response: found=%0d link=%0d dist=%0d updated=%0d",
                     rsp_ch.found, rsp_ch.route_link, rsp_ch.route_distance, rsp_ch.updated);
        end else begin
          want_route = expected_routes.pop_front();
          if (rsp_ch.found !== want_route.found || rsp_ch.route_link !== want_route.route_link ||
              rsp_ch.route_distance !== want_route.route_distance ||
              rsp_ch.updated !== want_route.updated) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected %s, got %s",
                       $sformatf("found=%0d link=%0d dist=%0d updated=%0d",
                                 want_route.found, want_route.route_link,
                                 want_route.route_distance, want_route.updated),
                       $sformatf("found=%0d link=%0d dist=%0d updated=%0d",
                                 rsp_ch.found, rsp_ch.route_link,
                                 rsp_ch.route_distance, rsp_ch.updated));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_gap(stall_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("** distance_vector_route_table: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits until no request is queued or in flight and every response has arrived.
  task automatic wait_quiescent();
    @(negedge clk);
    while (route_requests.size() > 0 || req_ch.valid || expected_routes.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the node id register: setup cycle, then access cycle.
  task automatic write_node_id(self_id_t id);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SELF_ID, 2'b00};
    pwdata <= PDataBits'(id);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    node_id = id;
  endtask

  task automatic random_phase(self_id_t id, int count, int idle, int stall);
    wait_quiescent();
    write_node_id(id);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) queue_request(random_request());
  endtask

  // Main sequence: reset, directed cases, then random phases over several node ids.
  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_LOOKUP;
    req_ch.dest = '0;
    req_ch.link_id = '0;
    req_ch.link_weight = '0;
    req_ch.nbr_distance = '0;
    rsp_ch.ready = 1'b0;
    node_id = '0;
    for (int i = 0; i < NodeCount; i++) begin
      tbl_present[i] = 1'b0;
      tbl_stale[i] = 1'b0;
      tbl_link[i] = '0;
      tbl_dist[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_node_id(6'd5);
    // Lookup of an absent entry, then merges into a new entry and longer, shorter and equal paths.
    queue_request(make_item(OP_LOOKUP, 6'd0, 4'd0, 16'd0, 16'd0));
    queue_request(make_item(OP_MERGE, 6'd10, 4'd3, 16'd5, 16'd7));
    queue_request(make_item(OP_MERGE, 6'd10, 4'd4, 16'd1, 16'd20));
    queue_request(make_item(OP_MERGE, 6'd10, 4'd6, 16'd1, 16'd10));
    queue_request(make_item(OP_MERGE, 6'd10, 4'd7, 16'd1, 16'd10));
    // Field extremes and saturation of the sum at infinity.
    queue_request(make_item(OP_ESTABLISH, 6'd63, 4'd15, 16'hFFFE, 16'hFFFF));
    queue_request(make_item(OP_MERGE, 6'd63, 4'd1, 16'hFFFE, 16'hFFFF));
    queue_request(make_item(OP_MERGE, 6'd20, 4'd2, 16'd0, 16'hFFFF));
    queue_request(make_item(OP_MERGE, 6'd20, 4'd9, 16'hFFFE, 16'hFFFE));
    queue_request(make_item(OP_MERGE, 6'd21, 4'd8, 16'd40000, 16'd40000));
    queue_request(make_item(OP_MERGE, 6'd21, 4'd11, 16'd0, 16'd0));
    // Merges toward the node's own id are ignored; establish is not.
    queue_request(make_item(OP_MERGE, 6'd5, 4'd2, 16'd1, 16'd1));
    queue_request(make_item(OP_ESTABLISH, 6'd5, 4'd12, 16'd9, 16'd0));
    queue_request(make_item(OP_MERGE, 6'd5, 4'd2, 16'd0, 16'd0));
    queue_request(make_item(OP_ESTABLISH, 6'd0, 4'd0, 16'd0, 16'hFFFF));
    queue_request(make_item(OP_LOOKUP, 6'd0, 4'd15, 16'hFFFE, 16'hFFFF));
    queue_request(make_item(OP_LOOKUP, 6'd63, 4'd0, 16'd0, 16'd0));
    // Stale entries read as infinity until rewritten.
    queue_request(make_item(OP_RESET_DIST, 6'd10, 4'd0, 16'd0, 16'd0));
    queue_request(make_item(OP_LOOKUP, 6'd21, 4'd0, 16'd0, 16'd0));
    queue_request(make_item(OP_MERGE, 6'd10, 4'd5, 16'hFFFE, 16'd0));
    queue_request(make_item(OP_MERGE, 6'd21, 4'd13, 16'd0, 16'hFFFF));
    queue_request(make_item(OP_ESTABLISH, 6'd21, 4'd14, 16'hFFFE, 16'd0));
    queue_request(make_item(OP_RESET_DIST, 6'd40, 4'd15, 16'hFFFE, 16'hFFFF));
    queue_request(make_item(OP_LOOKUP, 6'd63, 4'd0, 16'd0, 16'd0));

    random_phase(6'd63, 500, 0, 0);
    random_phase(6'd0, 450, 30, 30);
    random_phase(self_id_t'($urandom_range(1, 62)), 450, 60, 10);
    random_phase(self_id_t'($urandom_range(0, 63)), 400, 15, 70);
    wait_quiescent();
    repeat (6) @(posedge clk);

    if (failures == 0 && expected_routes.size() == 0) begin
      $display("** distance_vector_route_table: PASSED **");
    end else begin
      $display("** distance_vector_route_table: FAILED **");
    end
    $finish;
  end

endmodule
